// ===== hdl/sfwb_pkg.sv =====
// ----------------------------------------------------------------------------
// sfwb_pkg: shared types and constants for the star fit window bounds block
// Datapath widths, register indices and reset values, sideband word layouts.
// ----------------------------------------------------------------------------
package sfwb_pkg;

  // default fraction bits of the centre coordinates
  localparam int COORD_FRAC_DEF = 8;

  // datapath widths
  localparam int NUM_W   = 63;   // 3 * 2^30 * height
  localparam int DEN_W   = 40;   // subpixel_count * beta
  localparam int Y_W     = 22;   // cube root accumulator
  localparam int SQ_W    = 44;   // square of the cube root accumulator
  localparam int RAD_W   = 60;   // square root radicand
  localparam int ROOT_W  = 30;   // square root result, Q.16
  localparam int REM_W   = 32;   // square root partial remainder

  // chain lengths
  localparam int DIV_STEPS  = NUM_W;
  localparam int CBRT_STEPS = 22;
  localparam int SQRT_STEPS = RAD_W / 2;

  // configuration register indices
  typedef enum logic [1:0] {
    CFG_SUBPIXEL      = 2'd0,
    CFG_TABLE_HALF    = 2'd1,
    CFG_BETA_DEFAULT  = 2'd2,
    CFG_USE_STAR_BETA = 2'd3
  } cfg_index_t;

  // reset values of the configuration registers
  localparam logic [15:0] SUBPIXEL_RST   = 16'd1;
  localparam logic [9:0]  TABLE_HALF_RST = 10'd15;
  localparam logic [23:0] BETA_RST       = 24'd65536;

  // default half-width, 10.0 in Q.16
  localparam logic signed [31:0] HALF_DEFAULT = 32'sd655360;

  // per-star word carried alongside the division and root chains
  typedef struct packed {
    logic signed [23:0] cx;
    logic signed [23:0] cy;
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic               hpos;
    logic               inf;
  } side_t;

  // one result word
  typedef struct packed {
    logic signed [15:0] xl;
    logic signed [15:0] xh;
    logic signed [15:0] yl;
    logic signed [15:0] yh;
  } bounds_t;

endpackage

// ===== hdl/star_fit_window_bounds.sv =====
// ----------------------------------------------------------------------------
// star_fit_window_bounds: fitting rectangle around one star model
// Pipelined divide, cube root and square roots built as chains of digit cells.
// ----------------------------------------------------------------------------
// Accepts one star word every clock while input is not stalled and returns
// one bounds word per star in the same order, after the cell chains and any
// time spent waiting in the output buffer. The chains are 63 division cells
// for 3 * 2^30 * height / (subpixel_count * beta), 22 cube root cells, one
// multiply stage and 30 square root cells per axis, with one stage on each
// end. A two-word output buffer decouples the chains from the output stall,
// so input is stalled only when it is full. The user must see that configuration
// is written only while no star is in flight; the block does not enforce it.
module star_fit_window_bounds
  import sfwb_pkg::*;
#(
  parameter int COORD_FRAC = COORD_FRAC_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // configuration
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [23:0]        cfg_data,
  // input words
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] peak_height,
  input  logic signed [23:0] centre_x,
  input  logic signed [23:0] centre_y,
  input  logic signed [31:0] shape_x,
  input  logic signed [31:0] shape_y,
  input  logic [23:0]        star_beta,
  // output words
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] x_low,
  output logic signed [15:0] x_high,
  output logic signed [15:0] y_low,
  output logic signed [15:0] y_high
);

  localparam int SHL    = 16 - COORD_FRAC;
  localparam int CW     = 24 + SHL;
  localparam int SUM_W  = ((CW > 33) ? CW : 33) + 1;
  localparam int S_DIV  = DIV_STEPS;
  localparam int S_CBRT = S_DIV + CBRT_STEPS;
  localparam int S_MULT = S_CBRT + 1;
  localparam int S_SQRT = S_MULT + SQRT_STEPS;
  localparam int S_FIN  = S_SQRT + 1;

  // configuration registers
  logic [15:0] subpixel_count;
  logic [9:0]  table_half;
  logic [23:0] beta_default;
  logic        use_star_beta;

  always_ff @(posedge clk) begin
    if (rst) begin
      subpixel_count <= SUBPIXEL_RST;
      table_half     <= TABLE_HALF_RST;
      beta_default   <= BETA_RST;
      use_star_beta  <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_SUBPIXEL:      subpixel_count <= cfg_data[15:0];
        CFG_TABLE_HALF:    table_half     <= cfg_data[9:0];
        CFG_BETA_DEFAULT:  beta_default   <= cfg_data;
        CFG_USE_STAR_BETA: use_star_beta  <= cfg_data[0];
        default:           ;
      endcase
    end
  end

  // flow control: chains advance while the output buffer has room
  logic [1:0] cnt;
  logic       en;
  logic       push;
  logic       pop;

  assign en       = cnt != 2'd2;
  assign in_stall = !en;

  // stage valids and sideband words
  logic  v    [0:S_FIN];
  side_t side [0:S_SQRT];

  // input stage
  logic [23:0]      beta_sel;
  logic [32:0]      h3;
  logic [DEN_W-1:0] num_den;
  logic [DEN_W-1:0] rem_a  [0:S_DIV];
  logic [NUM_W-1:0] q_a    [0:S_DIV];
  logic [NUM_W-1:0] num_a  [0:S_DIV];
  logic [DEN_W-1:0] den_a  [0:S_DIV];

  assign beta_sel = use_star_beta ? star_beta : beta_default;
  assign h3       = {2'b00, peak_height[30:0]} + {1'b0, peak_height[30:0], 1'b0};
  assign num_den  = DEN_W'(subpixel_count) * DEN_W'(beta_sel);

  // input stage registers and sideband shift line
  always_ff @(posedge clk) begin
    if (en) begin
      num_a[0]      <= {h3, 30'd0};
      den_a[0]      <= num_den;
      rem_a[0]      <= '0;
      q_a[0]        <= '0;
      side[0].cx    <= centre_x;
      side[0].cy    <= centre_y;
      side[0].sx    <= shape_x;
      side[0].sy    <= shape_y;
      side[0].hpos  <= peak_height > 0;
      side[0].inf   <= (peak_height > 0) && (subpixel_count == '0 || beta_sel == '0);
      for (int i = 1; i <= S_SQRT; i++) side[i] <= side[i-1];
    end
  end

  // valid line
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= S_FIN; i++) v[i] <= 1'b0;
    end else if (en) begin
      v[0] <= in_valid;
      for (int i = 1; i <= S_FIN; i++) v[i] <= v[i-1];
    end
  end

  // division chain, one quotient bit per cell
  genvar g;
  generate
    for (g = 0; g < DIV_STEPS; g++) begin : g_div
      sfwb_div_cell #(.BIT(NUM_W - 1 - g)) u_cell (
        .clk     (clk),
        .en      (en),
        .rem_in  (rem_a[g]),
        .q_in    (q_a[g]),
        .num_in  (num_a[g]),
        .den_in  (den_a[g]),
        .rem_out (rem_a[g+1]),
        .q_out   (q_a[g+1]),
        .num_out (num_a[g+1]),
        .den_out (den_a[g+1])
      );
    end
  endgenerate

  // cube root chain, one root bit per cell
  logic [NUM_W-1:0] x_c  [0:CBRT_STEPS];
  logic [Y_W-1:0]   y_c  [0:CBRT_STEPS];
  logic [SQ_W-1:0]  sq_c [0:CBRT_STEPS];

  assign x_c[0]  = q_a[S_DIV];
  assign y_c[0]  = '0;
  assign sq_c[0] = '0;

  generate
    for (g = 0; g < CBRT_STEPS; g++) begin : g_cbrt
      sfwb_cbrt_cell #(.SH(NUM_W - 3*g)) u_cell (
        .clk    (clk),
        .en     (en),
        .x_in   (x_c[g]),
        .y_in   (y_c[g]),
        .sq_in  (sq_c[g]),
        .x_out  (x_c[g+1]),
        .y_out  (y_c[g+1]),
        .sq_out (sq_c[g+1])
      );
    end
  endgenerate

  // radicands t7 * shape * 64, one multiplier per axis
  logic [52:0] prod_x;
  logic [52:0] prod_y;
  logic [RAD_W-1:0] val_x [0:SQRT_STEPS];
  logic [RAD_W-1:0] val_y [0:SQRT_STEPS];
  logic [REM_W-1:0] rem_x [0:SQRT_STEPS];
  logic [REM_W-1:0] rem_y [0:SQRT_STEPS];
  logic [ROOT_W-1:0] rt_x [0:SQRT_STEPS];
  logic [ROOT_W-1:0] rt_y [0:SQRT_STEPS];

  assign prod_x = 53'(y_c[CBRT_STEPS]) * 53'(side[S_CBRT].sx[30:0]);
  assign prod_y = 53'(y_c[CBRT_STEPS]) * 53'(side[S_CBRT].sy[30:0]);

  always_ff @(posedge clk) begin
    if (en) begin
      val_x[0] <= {1'b0, prod_x, 6'd0};
      val_y[0] <= {1'b0, prod_y, 6'd0};
    end
  end

  assign rem_x[0] = '0;
  assign rem_y[0] = '0;
  assign rt_x[0]  = '0;
  assign rt_y[0]  = '0;

  // square root chains
  generate
    for (g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
      sfwb_sqrt_cell #(.K(g)) u_cx (
        .clk      (clk),
        .en       (en),
        .val_in   (val_x[g]),
        .rem_in   (rem_x[g]),
        .root_in  (rt_x[g]),
        .val_out  (val_x[g+1]),
        .rem_out  (rem_x[g+1]),
        .root_out (rt_x[g+1])
      );
      sfwb_sqrt_cell #(.K(g)) u_cy (
        .clk      (clk),
        .en       (en),
        .val_in   (val_y[g]),
        .rem_in   (rem_y[g]),
        .root_in  (rt_y[g]),
        .val_out  (val_y[g+1]),
        .rem_out  (rem_y[g+1]),
        .root_out (rt_y[g+1])
      );
    end
  endgenerate

  // half-width selection and capping
  function automatic logic signed [32:0] fudge_of(
    input logic              hpos,
    input logic              inf,
    input logic signed [31:0] shape,
    input logic [ROOT_W-1:0] root,
    input logic signed [31:0] cap
  );
    logic signed [31:0] h;
    h = HALF_DEFAULT;
    if (hpos && shape > 0) begin
      h = inf ? cap : $signed({2'b00, root});
    end
    if (h > cap) h = cap;
    return {h, 1'b0};
  endfunction

  // centre -/+ fudge, truncated toward zero and saturated
  function automatic logic signed [15:0] bound_of(
    input logic signed [23:0] c,
    input logic signed [32:0] f,
    input logic               plus
  );
    logic signed [SUM_W-1:0] cs;
    logic signed [SUM_W-1:0] s;
    logic signed [SUM_W-1:0] q;
    cs = SUM_W'(c) <<< SHL;
    s  = plus ? cs + SUM_W'(f) : cs - SUM_W'(f);
    q  = s >>> 16;
    if (s < 0 && s[15:0] != '0) q = q + SUM_W'(1);
    if (q > SUM_W'(32767)) return 16'sh7fff;
    if (q < -SUM_W'(32768)) return -16'sh8000;
    return q[15:0];
  endfunction

  logic signed [11:0] capi;
  logic signed [31:0] cap;
  logic signed [32:0] fx;
  logic signed [32:0] fy;
  side_t              sd;
  bounds_t            fin;

  assign capi = $signed({2'b00, table_half}) - 12'sd2;
  assign cap  = {{4{capi[11]}}, capi, 16'd0};
  assign sd   = side[S_SQRT];
  assign fx   = fudge_of(sd.hpos, sd.inf, sd.sx, rt_x[SQRT_STEPS], cap);
  assign fy   = fudge_of(sd.hpos, sd.inf, sd.sy, rt_y[SQRT_STEPS], cap);

  always_ff @(posedge clk) begin
    if (en) begin
      fin.xl <= bound_of(sd.cx, fx, 1'b0);
      fin.xh <= bound_of(sd.cx, fx, 1'b1);
      fin.yl <= bound_of(sd.cy, fy, 1'b0);
      fin.yh <= bound_of(sd.cy, fy, 1'b1);
    end
  end

  // two-word output buffer
  bounds_t e0;
  bounds_t e1;

  assign push = v[S_FIN] && en;
  assign pop  = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      case ({push, pop})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case ({push, pop})
      2'b10: begin
        if (cnt == 2'd0) e0 <= fin;
        else e1 <= fin;
      end
      2'b01: e0 <= e1;
      2'b11: e0 <= fin;
      default: ;
    endcase
  end

  assign out_valid = cnt != 2'd0;
  assign x_low     = e0.xl;
  assign x_high    = e0.xh;
  assign y_low     = e0.yl;
  assign y_high    = e0.yh;

  // checks
  a_cnt_range: assert property (@(posedge clk) disable iff (rst) cnt != 2'd3)
    else $error("output buffer count out of range");

  a_rose_push: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(push))
    else $error("output word appeared without a push");

  a_full_hold: assert property (@(posedge clk) disable iff (rst)
    (cnt == 2'd2 && !pop) |=> cnt == 2'd2)
    else $error("full buffer changed without a pop");

endmodule

// ===== hdl/sfwb_div_cell.sv =====
// ----------------------------------------------------------------------------
// sfwb_div_cell: one restoring division cell
// Brings down one numerator bit, trial-subtracts the divisor, passes on.
// ----------------------------------------------------------------------------
module sfwb_div_cell
  import sfwb_pkg::*;
#(
  parameter int BIT = 0
) (
  input  logic             clk,
  input  logic             en,
  input  logic [DEN_W-1:0] rem_in,
  input  logic [NUM_W-1:0] q_in,
  input  logic [NUM_W-1:0] num_in,
  input  logic [DEN_W-1:0] den_in,
  output logic [DEN_W-1:0] rem_out,
  output logic [NUM_W-1:0] q_out,
  output logic [NUM_W-1:0] num_out,
  output logic [DEN_W-1:0] den_out
);

  logic [DEN_W:0] trial;
  logic [DEN_W:0] diff;
  logic           ge;

  // trial subtract
  assign trial = {rem_in, num_in[BIT]};
  assign diff  = trial - {1'b0, den_in};
  assign ge    = trial >= {1'b0, den_in};

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      q_out   <= {q_in[NUM_W-2:0], ge};
      num_out <= num_in;
      den_out <= den_in;
    end
  end

endmodule

// ===== hdl/sfwb_cbrt_cell.sv =====
// ----------------------------------------------------------------------------
// sfwb_cbrt_cell: one digit cell of the integer cube root
// Doubles the root, tests 3y(y+1)+1 against the next three-bit group.
// ----------------------------------------------------------------------------
module sfwb_cbrt_cell
  import sfwb_pkg::*;
#(
  parameter int SH = 0
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] x_in,
  input  logic [Y_W-1:0]   y_in,
  input  logic [SQ_W-1:0]  sq_in,
  output logic [NUM_W-1:0] x_out,
  output logic [Y_W-1:0]   y_out,
  output logic [SQ_W-1:0]  sq_out
);

  logic [Y_W-1:0]   yd;
  logic [SQ_W-1:0]  sqd;
  logic [SQ_W+1:0]  s1;
  logic [SQ_W+1:0]  b;
  logic [NUM_W-1:0] xs;
  logic [NUM_W-1:0] bsh;
  logic             ge;

  // y' = 2y, sq' = y'^2 kept without a multiplier
  assign yd  = {y_in[Y_W-2:0], 1'b0};
  assign sqd = {sq_in[SQ_W-3:0], 2'b00};
  assign s1  = {2'b00, sqd} + (SQ_W+2)'(yd);
  assign b   = s1 + {s1[SQ_W:0], 1'b0} + (SQ_W+2)'(1);

  assign xs  = x_in >> SH;
  assign ge  = xs >= NUM_W'(b);
  assign bsh = NUM_W'(b) << SH;

  always_ff @(posedge clk) begin
    if (en) begin
      x_out  <= ge ? x_in - bsh : x_in;
      y_out  <= ge ? (yd | Y_W'(1)) : yd;
      sq_out <= ge ? sqd + SQ_W'({yd, 1'b0}) + SQ_W'(1) : sqd;
    end
  end

endmodule

// ===== hdl/sfwb_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// sfwb_sqrt_cell: one digit cell of the integer square root
// Brings down two radicand bits and settles one root bit.
// ----------------------------------------------------------------------------
module sfwb_sqrt_cell
  import sfwb_pkg::*;
#(
  parameter int K = 0
) (
  input  logic              clk,
  input  logic              en,
  input  logic [RAD_W-1:0]  val_in,
  input  logic [REM_W-1:0]  rem_in,
  input  logic [ROOT_W-1:0] root_in,
  output logic [RAD_W-1:0]  val_out,
  output logic [REM_W-1:0]  rem_out,
  output logic [ROOT_W-1:0] root_out
);

  logic [REM_W+1:0] r4;
  logic [REM_W+1:0] t;
  logic [REM_W+1:0] diff;
  logic             ge;

  // partial remainder against 4*root + 1
  assign r4   = {rem_in, val_in[RAD_W-1-2*K -: 2]};
  assign t    = {{(REM_W-ROOT_W){1'b0}}, root_in, 2'b01};
  assign diff = r4 - t;
  assign ge   = r4 >= t;

  always_ff @(posedge clk) begin
    if (en) begin
      val_out  <= val_in;
      rem_out  <= ge ? diff[REM_W-1:0] : r4[REM_W-1:0];
      root_out <= {root_in[ROOT_W-2:0], ge};
    end
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for star_fit_window_bounds
// Drives star words with random idling and back-pressure, predicts each
// bounds word in integer arithmetic and checks the results in order.
// ----------------------------------------------------------------------------
module tb;
  import sfwb_pkg::*;

  localparam int COORD_FRAC = 8;
  localparam int DRAIN_CYCLES = 140;

  typedef struct {
    logic signed [31:0] height;
    logic signed [23:0] cx;
    logic signed [23:0] cy;
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic [23:0]        beta;
  } star_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [23:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] peak_height = '0;
  logic signed [23:0] centre_x = '0;
  logic signed [23:0] centre_y = '0;
  logic signed [31:0] shape_x = '0;
  logic signed [31:0] shape_y = '0;
  logic [23:0] star_beta = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] x_low, x_high, y_low, y_high;

  // mirror of the configuration registers
  logic [15:0] subpixel_mirror = SUBPIXEL_RST;
  logic [9:0]  table_half_mirror = TABLE_HALF_RST;
  logic [23:0] beta_mirror = BETA_RST;
  logic        star_beta_mirror = 1'b0;

  bounds_t pending_bounds[$];
  int errors = 0;
  int send_idle = 0;
  int recv_idle = 0;
  int recv_hold = 0;

  star_fit_window_bounds #(.COORD_FRAC(COORD_FRAC)) dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

  // integer cube root, one bit per step
  function automatic longint unsigned cube_root(longint unsigned x);
    longint unsigned y, b;
    y = 0;
    for (int s = 63; s >= 0; s -= 3) begin
      y = y << 1;
      b = 3 * y * (y + 1) + 1;
      if ((x >> s) >= b) begin
        x -= b << s;
        y++;
      end
    end
    return y;
  endfunction

  function automatic longint unsigned square_root(longint unsigned x);
    longint unsigned r, bit_v;
    r = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > x) bit_v >>= 2;
    while (bit_v != 0) begin
      if (x >= r + bit_v) begin
        x -= r + bit_v;
        r = (r >> 1) + bit_v;
      end else begin
        r >>= 1;
      end
      bit_v >>= 2;
    end
    return r;
  endfunction

  // doubled half-width of one axis in Q.16
  function automatic longint axis_span(bit hpos, bit inf_t, longint unsigned t7,
                                       longint shape, longint cap);
    longint h;
    h = longint'(HALF_DEFAULT);
    if (hpos && shape > 0) begin
      if (inf_t) h = cap;
      else h = longint'(square_root(t7 * longint'(shape) * 64));
    end
    if (h > cap) h = cap;
    return 2 * h;
  endfunction

  function automatic logic signed [15:0] clamp16(longint v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  function automatic bounds_t predict_bounds(star_t s);
    longint unsigned beta, denom, t7, num;
    longint h, cap, fx, fy, cx16, cy16;
    bit hpos, inf_t;
    bounds_t b;
    h = longint'(s.height);
    beta = star_beta_mirror ? longint'(s.beta) : longint'(beta_mirror);
    denom = longint'(subpixel_mirror) * beta;
    hpos = h > 0;
    inf_t = 1'b0;
    t7 = 0;
    cap = (longint'(table_half_mirror) - 2) * 65536;
    if (hpos) begin
      if (denom == 0) begin
        inf_t = 1'b1;
      end else begin
        num = (64'd3 << 30) * h;
        t7 = cube_root(num / denom);
      end
    end
    fx = axis_span(hpos, inf_t, t7, longint'(s.sx), cap);
    fy = axis_span(hpos, inf_t, t7, longint'(s.sy), cap);
    cx16 = longint'(s.cx) * (64'sd1 << (16 - COORD_FRAC));
    cy16 = longint'(s.cy) * (64'sd1 << (16 - COORD_FRAC));
    b.xl = clamp16((cx16 - fx) / 65536);
    b.xh = clamp16((cx16 + fx) / 65536);
    b.yl = clamp16((cy16 - fy) / 65536);
    b.yh = clamp16((cy16 + fy) / 65536);
    return b;
  endfunction

  // receiver stall, with an optional long hold-off
  always @(negedge clk) begin
    if (recv_hold > 0) begin
      out_stall <= 1'b1;
      recv_hold <= recv_hold - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  // result checker
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_bounds.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
      end else begin
        bounds_t e;
        e = pending_bounds.pop_front();
        if (x_low !== e.xl) begin
          $error("x_low expected %0d got %0d", e.xl, x_low); errors++;
        end
        if (x_high !== e.xh) begin
          $error("x_high expected %0d got %0d", e.xh, x_high); errors++;
        end
        if (y_low !== e.yl) begin
          $error("y_low expected %0d got %0d", e.yl, y_low); errors++;
        end
        if (y_high !== e.yh) begin
          $error("y_high expected %0d got %0d", e.yh, y_high); errors++;
        end
      end
    end
  end

  // send one star word; called and returns at a falling edge
  task automatic send_star(star_t s);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    peak_height <= s.height;
    centre_x <= s.cx;
    centre_y <= s.cy;
    shape_x <= s.sx;
    shape_y <= s.sy;
    star_beta <= s.beta;
    do @(posedge clk); while (in_stall);
    pending_bounds.push_back(predict_bounds(s));
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_bounds.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(cfg_index_t idx, logic [23:0] value);
    drain_results();
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
    case (idx)
      CFG_SUBPIXEL:      subpixel_mirror = value[15:0];
      CFG_TABLE_HALF:    table_half_mirror = value[9:0];
      CFG_BETA_DEFAULT:  beta_mirror = value;
      CFG_USE_STAR_BETA: star_beta_mirror = value[0];
    endcase
  endtask

  function automatic star_t make_star(longint h, longint cx, longint cy,
                                      longint sx, longint sy, longint beta);
    star_t s;
    s.height = 32'(h); s.cx = 24'(cx); s.cy = 24'(cy);
    s.sx = 32'(sx); s.sy = 32'(sy); s.beta = 24'(beta);
    return s;
  endfunction

  // random star, mostly in a physically sensible range
  function automatic star_t random_star();
    star_t s;
    case ($urandom_range(3))
      0: s.height = $urandom;
      1: s.height = $urandom_range(1, 1 << 18);
      2: s.height = $urandom_range(1 << 18, 32'h7fffffff);
      default: s.height = 32'(-$signed({1'b0, $urandom_range(0, 1 << 12)}));
    endcase
    s.cx = ($urandom_range(2) == 0) ? 24'($urandom) : 24'($urandom_range(0, 1 << 20));
    s.cy = ($urandom_range(2) == 0) ? 24'($urandom) : 24'($urandom_range(0, 1 << 20));
    case ($urandom_range(3))
      0: s.sx = $urandom;
      3: s.sx = 32'(-$signed({1'b0, $urandom_range(0, 1 << 20)}));
      default: s.sx = $urandom_range(1, 1 << 22);
    endcase
    case ($urandom_range(3))
      0: s.sy = $urandom;
      3: s.sy = 32'(-$signed({1'b0, $urandom_range(0, 1 << 20)}));
      default: s.sy = $urandom_range(1, 1 << 22);
    endcase
    s.beta = ($urandom_range(1) == 0) ? 24'($urandom) : 24'($urandom_range(1, 1 << 18));
    return s;
  endfunction

  // field extremes and the special cases under the reset settings
  task automatic test_directed();
    send_star(make_star(32'sh7fffffff, 24'sh7fffff, 24'sh7fffff,
                        32'sh7fffffff, 32'sh7fffffff, 24'hffffff));
    send_star(make_star(-32'sh80000000, -24'sh800000, -24'sh800000,
                        -32'sh80000000, -32'sh80000000, 24'h1));
    send_star(make_star(0, 0, 0, 0, 0, 0));
    send_star(make_star(1, 1, -1, 1, 1, 1));
    send_star(make_star(25600, 12800, 25600, 104857, 209715, 65536));
    send_star(make_star(25600, 12800, 25600, -5, 209715, 65536));
    send_star(make_star(-1, 8000, 9000, 104857, 104857, 65536));
    send_star(make_star(32'sh01000000, 24'sh7f0000, -24'sh7f0000,
                        32'sh00100000, 32'sh00100000, 24'h10000));
  endtask

  task automatic test_special_settings();
    // zero divisor through the subpixel count
    write_reg(CFG_SUBPIXEL, 24'd0);
    send_star(make_star(25600, 2560, 2560, 1000, -1000, 65536));
    send_star(make_star(0, 2560, 2560, 1000, 1000, 65536));
    write_reg(CFG_SUBPIXEL, 24'd1);
    // zero divisor through the per-star beta
    write_reg(CFG_USE_STAR_BETA, 24'd1);
    send_star(make_star(25600, 2560, 2560, 1000, 1000, 0));
    send_star(make_star(25600, 2560, 2560, 1000, 1000, 24'hffffff));
    write_reg(CFG_BETA_DEFAULT, 24'd0);
    write_reg(CFG_USE_STAR_BETA, 24'd0);
    send_star(make_star(25600, 2560, 2560, 1000, 1000, 65536));
    // small table gives a negative cap
    write_reg(CFG_BETA_DEFAULT, 24'd65536);
    write_reg(CFG_TABLE_HALF, 24'd0);
    send_star(make_star(25600, 2560, 2560, 1000, 1000, 65536));
    send_star(make_star(-5, 2560, 2560, -1, -1, 65536));
    write_reg(CFG_TABLE_HALF, 24'd1);
    send_star(make_star(25600, 2560, 2560, 1000, 1000, 65536));
    write_reg(CFG_TABLE_HALF, 24'd15);
  endtask

  task automatic test_random(int n);
    repeat (n) send_star(random_star());
  endtask

  // receiver holds off while words keep coming, then sender waits for all
  task automatic test_backpressure();
    send_idle = 0;
    recv_idle = 0;
    drain_results();
    recv_hold = 400;
    test_random(200);
    drain_results();
    test_random(20);
    drain_results();
  endtask

  // one pass of random words under a set of register values
  task automatic test_setting(logic [23:0] sub, logic [23:0] th, logic [23:0] beta,
                              logic [23:0] use_b, int n);
    write_reg(CFG_SUBPIXEL, sub);
    write_reg(CFG_TABLE_HALF, th);
    write_reg(CFG_BETA_DEFAULT, beta);
    write_reg(CFG_USE_STAR_BETA, use_b);
    test_random(n);
  endtask

  task automatic test_idle_mode(int s_idle, int r_idle);
    send_idle = s_idle;
    recv_idle = r_idle;
    test_setting(24'd1, 24'd15, 24'd65536, 24'd0, 80);
    test_setting(24'd65535, 24'd1023, 24'd1, 24'd1, 80);
    test_setting(24'd3, 24'd3, 24'hffffff, 24'd0, 80);
    test_setting(24'd16, 24'd200, 24'd40000, 24'd1, 80);
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_special_settings();
    test_idle_mode(31, 73);
    test_idle_mode(73, 31);
    test_idle_mode(0, 0);
    test_backpressure();
    drain_results();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0 && pending_bounds.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== star_fit_window_bounds.f =====
hdl/sfwb_pkg.sv
hdl/sfwb_div_cell.sv
hdl/sfwb_cbrt_cell.sv
hdl/sfwb_sqrt_cell.sv
hdl/star_fit_window_bounds.sv
tb/tb.sv
